// ===== design/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/sprc_pkg.sv =====
`default_nettype none
package sprc_pkg;
    localparam logic [2:0] KIND_GLOBAL = 3'd0;
    localparam logic [2:0] KIND_MAC    = 3'd1;
    localparam logic [2:0] KIND_IPV4   = 3'd2;
    localparam logic [2:0] KIND_IPV6   = 3'd3;
    localparam logic [2:0] KIND_VLAN   = 3'd4;

    localparam logic [2:0] FAM_NONE = 3'd0;
    localparam logic [2:0] FAM_IPV4 = 3'd1;
    localparam logic [2:0] FAM_IPV6 = 3'd2;

    localparam logic [1:0] SRC_BLOCKLIST = 2'd0;
    localparam logic [1:0] SRC_EXPLICIT  = 2'd1;
    localparam logic [1:0] SRC_EMERGENCY = 2'd2;
    localparam logic [1:0] SRC_DEFAULT   = 2'd3;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [11:0] VLAN_MAX = 12'd4094;
    localparam logic [7:0]  V4_MAX   = 8'd32;
    localparam logic [7:0]  V6_MAX   = 8'd128;

    localparam logic [2:0] ADDR_ENTRIES = 3'd0;

    typedef struct packed {
        logic       sub;
        logic       eff;
        logic [1:0] src;
        logic [2:0] prio;
        logic [11:0] vlan;
        logic [7:0] prefix;
        logic [2:0] kind;
    } meta_t;

    // top p bits of a 64-bit word, p clamped at 64
    function automatic logic [63:0] top_mask(input logic [7:0] p);
        logic [63:0] m;
        if (p >= 8'd64)
        begin
            m = '1;
        end
        else
        begin
            m = ~({64{1'b1}} >> p[5:0]);
        end
        return m;
    endfunction
endpackage
`default_nettype wire

// ===== design/scoped_rule_priority_classifier_top.sv =====
// channel  | dir | tdata / tuser content
// s_axis   | in  | one load or query item, opcode on tuser
// m_axis   | out | one classification result per item
// apb      | in  | entries_in_use at address 0
//
// a load goes through the input transfer and then the result transfer
// a query goes through the input transfer, a scan of min(entries_in_use,
// RULE_SLOTS) entries plus a drain of the last read, the winner latch and
// the result transfer; one rule entry is read and compared per scan cycle
// the rule table lives in memories; only valid bits are reset
// input is not ready while an item is in work or its result waits for a transfer
`default_nettype none
`include "assert_macros.svh"
module scoped_rule_priority_classifier_top #(
    parameter int RULE_SLOTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode
    input  wire logic         s_axis_tuser,
    // entry_index, rule_ident, scope_kind, addr_high, addr_low, mac_value,
    // prefix_len, vlan_num, source_kind, block_effect, option_bits (from bit 0), pad
    input  wire logic [279:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status, matched, winner_ident, winner_effect, winner_source,
    // winner_priority (from bit 0)
    output logic [71:0]       m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam logic [1:0] ADDR_ENTRIES_W = sprc_pkg::ADDR_ENTRIES[1:0];

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_OUT} state_t;

    // unpacked input fields
    logic         in_op;
    logic [5:0]   in_idx;
    logic [63:0]  in_id, in_ah, in_al;
    logic [2:0]   in_kind, in_opt;
    logic [47:0]  in_mac;
    logic [7:0]   in_plen;
    logic [11:0]  in_vlan;
    logic [1:0]   in_src;
    logic         in_eff;
    assign in_op   = s_axis_tuser;
    assign in_idx  = s_axis_tdata[5:0];
    assign in_id   = s_axis_tdata[69:6];
    assign in_kind = s_axis_tdata[72:70];
    assign in_ah   = s_axis_tdata[136:73];
    assign in_al   = s_axis_tdata[200:137];
    assign in_mac  = s_axis_tdata[248:201];
    assign in_plen = s_axis_tdata[256:249];
    assign in_vlan = s_axis_tdata[268:257];
    assign in_src  = s_axis_tdata[270:269];
    assign in_eff  = s_axis_tdata[271];
    assign in_opt  = s_axis_tdata[274:272];

    // configuration
    logic [6:0] entries_reg;
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_ENTRIES_W)
        begin
            prdata = {25'd0, entries_reg};
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_ENTRIES_W)
        begin
            entries_reg <= pwdata[6:0];
        end
    end

    // load check and canonical form
    logic        ld_ok;
    logic [63:0] ld_ah, ld_al, mh, ml;
    logic [47:0] ld_mac;
    sprc_pkg::meta_t ld_meta;
    always_comb
    begin
        ld_ok = in_id != 64'd0;
        ld_ah = '0;
        ld_al = '0;
        ld_mac = '0;
        ld_meta = '0;
        mh = sprc_pkg::top_mask(in_plen);
        ml = (in_plen > 8'd64) ? sprc_pkg::top_mask(in_plen - 8'd64) : 64'd0;
        if (in_src == sprc_pkg::SRC_BLOCKLIST && !in_eff) ld_ok = 1'b0;
        if (in_src == sprc_pkg::SRC_EMERGENCY && in_eff) ld_ok = 1'b0;
        if (in_src == sprc_pkg::SRC_DEFAULT) ld_ok = 1'b0;
        case (in_kind)
            sprc_pkg::KIND_GLOBAL: ;
            sprc_pkg::KIND_MAC: ld_mac = in_mac;
            sprc_pkg::KIND_IPV4:
            begin
                if (in_plen > sprc_pkg::V4_MAX) ld_ok = 1'b0;
                ld_meta.prefix = in_plen;
                ld_ah = in_ah & sprc_pkg::top_mask((in_plen > sprc_pkg::V4_MAX) ?
                                                   sprc_pkg::V4_MAX : in_plen);
            end
            sprc_pkg::KIND_IPV6:
            begin
                if (in_plen > sprc_pkg::V6_MAX) ld_ok = 1'b0;
                ld_meta.prefix = in_plen;
                ld_ah = in_ah & mh;
                ld_al = in_al & ml;
            end
            sprc_pkg::KIND_VLAN:
            begin
                if (in_vlan > sprc_pkg::VLAN_MAX) ld_ok = 1'b0;
                ld_meta.vlan = in_vlan;
            end
            default: ld_ok = 1'b0;
        endcase
        ld_meta.kind = in_kind;
        ld_meta.src  = in_src;
        ld_meta.eff  = in_eff;
        ld_meta.sub  = in_opt[0];
        if (in_src == sprc_pkg::SRC_EMERGENCY)
            ld_meta.prio = 3'd6;
        else if (in_src == sprc_pkg::SRC_EXPLICIT)
            ld_meta.prio = !in_eff ? ((in_kind == sprc_pkg::KIND_GLOBAL) ? 3'd4 : 3'd5)
                                   : ((in_kind == sprc_pkg::KIND_GLOBAL) ? 3'd2 : 3'd3);
        else
            ld_meta.prio = 3'd1;
    end

    // rule table memories
    logic [63:0] mem_id [RULE_SLOTS];
    logic [63:0] mem_ah [RULE_SLOTS];
    logic [63:0] mem_al [RULE_SLOTS];
    logic [47:0] mem_mac [RULE_SLOTS];
    logic [29:0] mem_meta [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] valid_reg;

    logic accept_in, do_write;
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign do_write  = accept_in && in_op == sprc_pkg::OP_LOAD && ld_ok &&
                       ({26'd0, in_idx} < RULE_SLOTS);

    logic [IW-1:0] wr_idx;
    assign wr_idx = IW'(in_idx);

    // scan control
    state_t     state_reg;
    logic [CW-1:0] cnt_reg, limit_reg;
    logic [IW-1:0] rd_addr;
    logic [63:0] rd_id_reg, rd_ah_reg, rd_al_reg;
    logic [47:0] rd_mac_reg;
    sprc_pkg::meta_t rd_meta_reg;
    logic        rd_vld_reg, rd_live_reg;

    assign rd_addr = cnt_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_id[wr_idx]   <= in_id;
            mem_ah[wr_idx]   <= ld_ah;
            mem_al[wr_idx]   <= ld_al;
            mem_mac[wr_idx]  <= ld_mac;
            mem_meta[wr_idx] <= ld_meta;
        end
        rd_id_reg   <= mem_id[rd_addr];
        rd_ah_reg   <= mem_ah[rd_addr];
        rd_al_reg   <= mem_al[rd_addr];
        rd_mac_reg  <= mem_mac[rd_addr];
        rd_meta_reg <= mem_meta[rd_addr];
    end

    // query held during scan
    logic [2:0]  q_fam_reg, q_opt_reg;
    logic [63:0] q_ah_reg, q_al_reg;
    logic [47:0] q_mac_reg;
    logic [11:0] q_vlan_reg;

    // compare unit for one entry
    logic        hit;
    logic [63:0] qmh, qml;
    always_comb
    begin
        qmh = sprc_pkg::top_mask(rd_meta_reg.prefix);
        qml = (rd_meta_reg.prefix > 8'd64) ?
              sprc_pkg::top_mask(rd_meta_reg.prefix - 8'd64) : 64'd0;
        hit = 1'b0;
        case (rd_meta_reg.kind)
            sprc_pkg::KIND_GLOBAL: hit = 1'b1;
            sprc_pkg::KIND_MAC: hit = q_opt_reg[1] && q_mac_reg == rd_mac_reg;
            sprc_pkg::KIND_IPV4:
                hit = q_fam_reg == sprc_pkg::FAM_IPV4 &&
                      (q_ah_reg & sprc_pkg::top_mask((rd_meta_reg.prefix > sprc_pkg::V4_MAX) ?
                       sprc_pkg::V4_MAX : rd_meta_reg.prefix)) == rd_ah_reg;
            sprc_pkg::KIND_IPV6:
                hit = q_fam_reg == sprc_pkg::FAM_IPV6 && (q_ah_reg & qmh) == rd_ah_reg &&
                      (q_al_reg & qml) == rd_al_reg;
            sprc_pkg::KIND_VLAN: hit = q_opt_reg[2] && q_vlan_reg == rd_meta_reg.vlan;
            default: hit = 1'b0;
        endcase
        hit = hit && rd_vld_reg && rd_live_reg && (q_opt_reg[0] || rd_meta_reg.sub);
    end

    // best-so-far
    logic        found_reg;
    logic [63:0] best_id_reg;
    logic [2:0]  best_prio_reg;
    logic [1:0]  best_src_reg;
    logic        best_eff_reg;
    logic        take;
    assign take = hit && (!found_reg || rd_meta_reg.prio > best_prio_reg ||
                  (rd_meta_reg.prio == best_prio_reg && rd_id_reg < best_id_reg));

    logic [71:0] out_reg;
    logic [CW-1:0] lim_next;
    logic        q_bad;
    assign q_bad = in_kind > sprc_pkg::FAM_IPV6 ||
                   (in_opt[2] && in_vlan > sprc_pkg::VLAN_MAX);
    assign lim_next = ({25'd0, entries_reg} > RULE_SLOTS) ? CW'(RULE_SLOTS)
                                                          : CW'(entries_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            rd_live_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            best_id_reg   <= '0;
            best_prio_reg <= '0;
            best_src_reg  <= '0;
            best_eff_reg  <= 1'b0;
            q_fam_reg     <= '0;
            q_opt_reg     <= '0;
            q_ah_reg      <= '0;
            q_al_reg      <= '0;
            q_mac_reg     <= '0;
            q_vlan_reg    <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (do_write) valid_reg[wr_idx] <= 1'b1;
            rd_vld_reg  <= valid_reg[rd_addr];
            rd_live_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        found_reg  <= 1'b0;
                        cnt_reg    <= '0;
                        q_fam_reg  <= in_kind;
                        q_opt_reg  <= in_opt;
                        q_ah_reg   <= in_ah;
                        q_al_reg   <= in_al;
                        q_mac_reg  <= in_mac;
                        q_vlan_reg <= in_vlan;
                        // no-match payload; a query winner overwrites it later
                        out_reg <= {3'd0, sprc_pkg::SRC_DEFAULT, 1'b0, 64'd0, 1'b0,
                                    (in_op == sprc_pkg::OP_LOAD) ? !ld_ok : q_bad};
                        if (in_op == sprc_pkg::OP_LOAD || q_bad)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            limit_reg <= lim_next;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // issue read at cnt, compare the previous one
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        best_id_reg   <= rd_id_reg;
                        best_prio_reg <= rd_meta_reg.prio;
                        best_src_reg  <= rd_meta_reg.src;
                        best_eff_reg  <= rd_meta_reg.eff;
                    end
                    if (cnt_reg < limit_reg)
                    begin
                        rd_live_reg <= 1'b1;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (found_reg)
                    begin
                        out_reg <= {best_prio_reg, best_src_reg, best_eff_reg, best_id_reg,
                                    1'b1, 1'b0};
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = state_reg == S_OUT;
    assign m_axis_tdata  = out_reg;

    `ASSERT_IMPL(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_reg == S_SCAN, cnt_reg <= limit_reg)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire
